// File: sv/alpha_premultiply_unit_defines.svh
// ---------------------------------------------------------------------------
// alpha premultiply unit assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef ALPHA_PREMULTIPLY_UNIT_DEFINES_SVH
`define ALPHA_PREMULTIPLY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define APU_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");
`define APU_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");
`else
`define APU_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define APU_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

// File: sv/apu_pkg.sv
// ---------------------------------------------------------------------------
// apu package
// shared types and constants of the alpha premultiply unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package apu_pkg;

   localparam int unsigned CHANNELS = 3;
   localparam int unsigned QUO_BITS = 8;

   localparam logic [7:0] FULL_SCALE = 8'd255;

   localparam logic CSR_DIRECTION = 1'b0;
   localparam logic CSR_SURFACE   = 1'b1;

   localparam logic DIR_PREMULTIPLY   = 1'b0;
   localparam logic DIR_UNPREMULTIPLY = 1'b1;

   typedef struct packed {
      logic [CHANNELS-1:0][7:0] rem;
      logic [CHANNELS-1:0][7:0] low;
      logic [CHANNELS-1:0][7:0] quo;
      logic [7:0]               divisor;
      logic [CHANNELS-1:0][7:0] color;
      logic [7:0]               alpha;
      logic                     last;
      logic                     bypass;
      logic [CHANNELS-1:0]      sat;
      logic                     na;
   } work_type;

endpackage

// File: sv/alpha_premultiply_unit.sv
// ---------------------------------------------------------------------------
// alpha premultiply unit
// premultiplies or unpremultiplies one 8-bit pixel per transaction
// ---------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   three colour bytes, alpha, last
//  rsp      out        rsp_valid/rsp_stall   three colours, alpha, last, flags
//  csr      in         csr_write             csr_index, csr_data
//
//  one transaction per clock while rsp does not stall; stages: multiply stage,
//  eight restoring divider stages (one quotient bit each), output register
//  every stage holds its transaction while the next one is full and stalled
//  req_stall rises only when all ten stages hold a transaction and rsp stalls
//  reset clears the stage valid bits and sets direction 0, surface argb32 1
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alpha_premultiply_unit_defines.svh"

module alpha_premultiply_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_chan_zero,
   input  logic [7:0] req_chan_one,
   input  logic [7:0] req_chan_two,
   input  logic [7:0] req_alpha_in,
   input  logic       req_last_pixel,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_res_zero,
   output logic [7:0] rsp_res_one,
   output logic [7:0] rsp_res_two,
   output logic [7:0] rsp_alpha_out,
   output logic       rsp_last_out,
   output logic       rsp_clipped,
   output logic       rsp_not_applied,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic       csr_data
);

   logic direction_ff;
   logic direction_in;
   logic surface_ff;
   logic surface_in;
   logic prep_ready;

   apu_pkg::work_type stage_data  [apu_pkg::QUO_BITS+1];
   logic              stage_valid [apu_pkg::QUO_BITS+1];
   logic              stage_ready [apu_pkg::QUO_BITS+1];

   // configuration registers
   always_comb begin
      direction_in = direction_ff;
      surface_in   = surface_ff;
      if (csr_write) begin
         case (csr_index)
            apu_pkg::CSR_DIRECTION: direction_in = csr_data;
            apu_pkg::CSR_SURFACE:   surface_in   = csr_data;
            default: begin
               direction_in = direction_ff;
               surface_in   = surface_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= apu_pkg::DIR_PREMULTIPLY;
         surface_ff   <= 1'b1;
      end else begin
         direction_ff <= direction_in;
         surface_ff   <= surface_in;
      end
   end

   apu_prep u_prep (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req_valid),
      .in_ready          (prep_ready),
      .chan_zero         (req_chan_zero),
      .chan_one          (req_chan_one),
      .chan_two          (req_chan_two),
      .alpha_in          (req_alpha_in),
      .last_pixel        (req_last_pixel),
      .direction         (direction_ff),
      .surface_is_argb32 (surface_ff),
      .out_valid         (stage_valid[0]),
      .out_ready         (stage_ready[0]),
      .out_data          (stage_data[0])
   );

   assign req_stall = !prep_ready;

   for (genvar k = 0; k < apu_pkg::QUO_BITS; k++) begin : g_div
      apu_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   apu_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stage_valid[apu_pkg::QUO_BITS]),
      .in_ready    (stage_ready[apu_pkg::QUO_BITS]),
      .in_data     (stage_data[apu_pkg::QUO_BITS]),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .res_zero    (rsp_res_zero),
      .res_one     (rsp_res_one),
      .res_two     (rsp_res_two),
      .alpha_out   (rsp_alpha_out),
      .last_out    (rsp_last_out),
      .clipped     (rsp_clipped),
      .not_applied (rsp_not_applied)
   );

   // assertions
   `APU_ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall)
   `APU_ASSERT_IMPLIES(a_clip_excludes_na, clock, reset,
      rsp_valid && rsp_clipped, !rsp_not_applied)
   `APU_ASSERT_IMPLIES(a_clip_saturates, clock, reset, rsp_valid && rsp_clipped,
      (rsp_res_zero == 8'hFF) || (rsp_res_one == 8'hFF) || (rsp_res_two == 8'hFF))
   `APU_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_res_zero) && $stable(rsp_alpha_out))

endmodule

// File: sv/apu_prep.sv
// ---------------------------------------------------------------------------
// apu prep stage
// forms the dividend per channel and the shared divisor, decodes bypass and saturation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        chan_zero,
   input  logic [7:0]        chan_one,
   input  logic [7:0]        chan_two,
   input  logic [7:0]        alpha_in,
   input  logic              last_pixel,
   input  logic              direction,
   input  logic              surface_is_argb32,
   output logic              out_valid,
   input  logic              out_ready,
   output apu_pkg::work_type out_data
);

   logic              valid_ff;
   logic              valid_in;
   apu_pkg::work_type data_ff;
   apu_pkg::work_type data_in;

   logic [apu_pkg::CHANNELS-1:0][7:0] colors;
   logic [7:0]  mult;
   logic [15:0] prod [apu_pkg::CHANNELS];
   logic        unpre;

   assign colors = {chan_two, chan_one, chan_zero};
   assign unpre  = surface_is_argb32 && (direction == apu_pkg::DIR_UNPREMULTIPLY);
   assign mult   = (direction == apu_pkg::DIR_UNPREMULTIPLY) ? apu_pkg::FULL_SCALE : alpha_in;

   always_comb begin
      data_in.divisor = (direction == apu_pkg::DIR_UNPREMULTIPLY) ? alpha_in
                                                                  : apu_pkg::FULL_SCALE;
      data_in.color   = colors;
      data_in.alpha   = alpha_in;
      data_in.last    = last_pixel;
      data_in.na      = !surface_is_argb32;
      data_in.bypass  = !surface_is_argb32 || (unpre && (alpha_in == 8'd0));
      for (int i = 0; i < apu_pkg::CHANNELS; i++) begin
         prod[i]            = 16'(colors[i]) * 16'(mult);
         data_in.rem[i]     = prod[i][15:8];
         data_in.low[i]     = prod[i][7:0];
         data_in.quo[i]     = 8'd0;
         data_in.sat[i]     = unpre && (alpha_in != 8'd0) && (colors[i] > alpha_in);
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: sv/apu_div_stage.sv
// ---------------------------------------------------------------------------
// apu divider stage
// one restoring division step per channel, one quotient bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  apu_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output apu_pkg::work_type out_data
);

   logic              valid_ff;
   logic              valid_in;
   apu_pkg::work_type data_ff;
   apu_pkg::work_type data_in;

   logic [8:0] trial [apu_pkg::CHANNELS];
   logic [8:0] diff  [apu_pkg::CHANNELS];
   logic       qbit  [apu_pkg::CHANNELS];

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < apu_pkg::CHANNELS; i++) begin
         trial[i]       = {in_data.rem[i], in_data.low[i][7]};
         diff[i]        = trial[i] - {1'b0, in_data.divisor};
         qbit[i]        = (trial[i] >= {1'b0, in_data.divisor});
         data_in.rem[i] = qbit[i] ? diff[i][7:0] : trial[i][7:0];
         data_in.low[i] = {in_data.low[i][6:0], 1'b0};
         data_in.quo[i] = {in_data.quo[i][6:0], qbit[i]};
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: sv/apu_finish.sv
// ---------------------------------------------------------------------------
// apu finish stage
// picks quotient, saturated or bypassed colour and registers the transaction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_finish (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  apu_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [7:0]        res_zero,
   output logic [7:0]        res_one,
   output logic [7:0]        res_two,
   output logic [7:0]        alpha_out,
   output logic              last_out,
   output logic              clipped,
   output logic              not_applied
);

   logic        valid_ff;
   logic        valid_in;
   logic [apu_pkg::CHANNELS-1:0][7:0] res_ff;
   logic [apu_pkg::CHANNELS-1:0][7:0] res_in;
   logic [7:0]  alpha_ff;
   logic        last_ff;
   logic        clipped_ff;
   logic        na_ff;

   always_comb begin
      for (int i = 0; i < apu_pkg::CHANNELS; i++) begin
         if (in_data.bypass) begin
            res_in[i] = in_data.color[i];
         end else if (in_data.sat[i]) begin
            res_in[i] = apu_pkg::FULL_SCALE;
         end else begin
            res_in[i] = in_data.quo[i];
         end
      end
   end

   assign in_ready = !valid_ff || !out_stall;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff     <= res_in;
         alpha_ff   <= in_data.alpha;
         last_ff    <= in_data.last;
         clipped_ff <= (|in_data.sat) && !in_data.bypass;
         na_ff      <= in_data.na;
      end
   end

   assign out_valid   = valid_ff;
   assign res_zero    = res_ff[0];
   assign res_one     = res_ff[1];
   assign res_two     = res_ff[2];
   assign alpha_out   = alpha_ff;
   assign last_out    = last_ff;
   assign clipped     = clipped_ff;
   assign not_applied = na_ff;

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// alpha premultiply unit testbench
// drives pixel transactions through the unit under random stalls and gaps,
// predicts each converted pixel from the current direction and surface
// settings, and compares every rsp transaction field by field in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned TAIL_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES = 48;
   localparam int unsigned PHASE_ITEMS = 140;

   typedef struct packed {
      logic [7:0] res_zero;
      logic [7:0] res_one;
      logic [7:0] res_two;
      logic [7:0] alpha_out;
      logic       last_out;
      logic       clipped;
      logic       not_applied;
   } pixel_out_type;

   class premultiply_scoreboard;
      logic          direction;
      logic          argb32;
      pixel_out_type expected_pixels[$];
      int unsigned   mismatches;

      function new();
         direction  = apu_pkg::DIR_PREMULTIPLY;
         argb32     = 1'b1;
         mismatches = 0;
      endfunction

      function void write_register(logic index, logic data);
         if (index == apu_pkg::CSR_DIRECTION) begin
            direction = data;
         end else begin
            argb32 = data;
         end
      endfunction

      function pixel_out_type convert_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                            logic [7:0] a, logic last);
         logic [7:0]    chan_in[3];
         logic [7:0]    chan_res[3];
         int unsigned   q;
         pixel_out_type r;
         chan_in = '{c0, c1, c2};
         r.clipped = 1'b0;
         r.not_applied = !argb32;
         for (int i = 0; i < 3; i++) begin
            chan_res[i] = chan_in[i];
            if (argb32 && direction == apu_pkg::DIR_PREMULTIPLY) begin
               q = (32'(chan_in[i]) * 32'(a)) / 32'(apu_pkg::FULL_SCALE);
               chan_res[i] = q[7:0];
            end else if (argb32 && a != 8'd0) begin
               q = (32'(chan_in[i]) * 32'(apu_pkg::FULL_SCALE)) / 32'(a);
               if (q > 32'(apu_pkg::FULL_SCALE)) begin
                  q = 32'(apu_pkg::FULL_SCALE);
                  r.clipped = 1'b1;
               end
               chan_res[i] = q[7:0];
            end
         end
         r.res_zero  = chan_res[0];
         r.res_one   = chan_res[1];
         r.res_two   = chan_res[2];
         r.alpha_out = a;
         r.last_out  = last;
         return r;
      endfunction

      function void note_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                               logic [7:0] a, logic last);
         expected_pixels.push_back(convert_pixel(c0, c1, c2, a, last));
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_pixel(pixel_out_type got);
         pixel_out_type want;
         if (expected_pixels.size() == 0) begin
            $error("rsp transaction with no expected pixel");
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("res_zero", 32'(want.res_zero), 32'(got.res_zero));
         compare_field("res_one", 32'(want.res_one), 32'(got.res_one));
         compare_field("res_two", 32'(want.res_two), 32'(got.res_two));
         compare_field("alpha_out", 32'(want.alpha_out), 32'(got.alpha_out));
         compare_field("last_out", 32'(want.last_out), 32'(got.last_out));
         compare_field("clipped", 32'(want.clipped), 32'(got.clipped));
         compare_field("not_applied", 32'(want.not_applied), 32'(got.not_applied));
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_chan_zero = 8'd0;
   logic [7:0] req_chan_one = 8'd0;
   logic [7:0] req_chan_two = 8'd0;
   logic [7:0] req_alpha_in = 8'd0;
   logic       req_last_pixel = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_res_zero;
   logic [7:0] rsp_res_one;
   logic [7:0] rsp_res_two;
   logic [7:0] rsp_alpha_out;
   logic       rsp_last_out;
   logic       rsp_clipped;
   logic       rsp_not_applied;
   logic       csr_write = 1'b0;
   logic       csr_index = apu_pkg::CSR_DIRECTION;
   logic       csr_data = 1'b0;

   premultiply_scoreboard board = new();

   bit          steady_stream = 1'b0;
   int unsigned holds_requested = 0;
   int unsigned holds_started = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   alpha_premultiply_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_chan_zero  (req_chan_zero),
      .req_chan_one   (req_chan_one),
      .req_chan_two   (req_chan_two),
      .req_alpha_in   (req_alpha_in),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_res_zero   (rsp_res_zero),
      .rsp_res_one    (rsp_res_one),
      .rsp_res_two    (rsp_res_two),
      .rsp_alpha_out  (rsp_alpha_out),
      .rsp_last_out   (rsp_last_out),
      .rsp_clipped    (rsp_clipped),
      .rsp_not_applied(rsp_not_applied),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_pixel(req_chan_zero, req_chan_one, req_chan_two, req_alpha_in,
                          req_last_pixel);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_pixel({rsp_res_zero, rsp_res_one, rsp_res_two, rsp_alpha_out,
                            rsp_last_out, rsp_clipped, rsp_not_applied});
      end
      if (!reset && csr_write) begin
         board.write_register(csr_index, csr_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (holds_started != holds_requested) begin
         holds_started = holds_requested;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady_stream && ($urandom_range(0, 99) < 9);
      end
   end

   task automatic write_register(input logic index, input logic data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
                             input logic [7:0] c2, input logic [7:0] a,
                             input logic last);
      @(negedge clock);
      if (!steady_stream && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_chan_zero  <= c0;
      req_chan_one   <= c1;
      req_chan_two   <= c2;
      req_alpha_in   <= a;
      req_last_pixel <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random_pixel();
      logic [7:0] a;
      logic [7:0] c[3];
      logic       last;
      a = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
         a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      // mostly valid premultiplied data when dividing, so results stay in range
      if (board.argb32 && board.direction == apu_pkg::DIR_UNPREMULTIPLY
          && $urandom_range(0, 3) != 0) begin
         for (int i = 0; i < 3; i++) c[i] = 8'($urandom_range(0, 32'(a)));
      end else begin
         for (int i = 0; i < 3; i++) c[i] = 8'($urandom_range(0, 255));
      end
      last = ($urandom_range(0, 15) == 0);
      send_pixel(c[0], c[1], c[2], a, last);
   endtask

   task automatic set_mode(input logic dir, input logic argb32);
      wait_until_drained();
      write_register(apu_pkg::CSR_DIRECTION, dir);
      write_register(apu_pkg::CSR_SURFACE, argb32);
   endtask

   initial begin
      logic phase_dir[6];
      logic phase_surface[6];
      phase_dir     = '{apu_pkg::DIR_PREMULTIPLY, apu_pkg::DIR_UNPREMULTIPLY,
                        apu_pkg::DIR_UNPREMULTIPLY, apu_pkg::DIR_PREMULTIPLY,
                        apu_pkg::DIR_UNPREMULTIPLY, apu_pkg::DIR_PREMULTIPLY};
      phase_surface = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // premultiply corners
      set_mode(apu_pkg::DIR_PREMULTIPLY, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd128, 8'd1, 8'd0, 1'b0);
      send_pixel(8'd200, 8'd100, 8'd50, 8'd128, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd170, 8'd1, 1'b1);
      send_pixel(8'd1, 8'd254, 8'd85, 8'd254, 1'b0);

      // unpremultiply: zero alpha, saturation, exact and edge quotients
      set_mode(apu_pkg::DIR_UNPREMULTIPLY, 1'b1);
      send_pixel(8'd77, 8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd200, 8'd50, 8'd10, 8'd100, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd1, 8'd1, 1'b0);
      send_pixel(8'd1, 8'd254, 8'd255, 8'd1, 1'b0);
      send_pixel(8'd128, 8'd64, 8'd32, 8'd128, 1'b0);
      send_pixel(8'd254, 8'd253, 8'd0, 8'd254, 1'b1);
      send_pixel(8'd255, 8'd254, 8'd127, 8'd254, 1'b0);

      // conversion disabled in both directions
      set_mode(apu_pkg::DIR_UNPREMULTIPLY, 1'b0);
      send_pixel(8'd12, 8'd34, 8'd56, 8'd78, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd200, 8'd0, 8'd255, 8'd100, 1'b0);
      set_mode(apu_pkg::DIR_PREMULTIPLY, 1'b0);
      send_pixel(8'd255, 8'd1, 8'd128, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);

      for (int p = 0; p < 6; p++) begin
         set_mode(phase_dir[p], phase_surface[p]);
         steady_stream = (p == 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((p == 3 || p == 4) && n == 20) begin
               holds_requested = holds_requested + 1;
            end
            if (p == 4 && n == 70) begin
               wait_until_drained();
            end
            send_random_pixel();
         end
      end
      steady_stream = 1'b0;

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         $error("%0d expected pixels never arrived", board.pending());
      end
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
